// ----- rtl/dls_pkg.sv -----
// Shared constants, types and helper functions for the dense layer softmax block.
`timescale 1ns / 1ps
package dls_pkg;

  localparam int IN_DIM    = 64;
  localparam int OUT_DIM   = 16;
  localparam int EXP_DEPTH = 256;
  localparam int MAX_RES   = 16;
  localparam int N_RES     = (OUT_DIM < MAX_RES) ? OUT_DIM : MAX_RES;

  localparam int W_DEPTH = IN_DIM * OUT_DIM;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int OJ_W    = $clog2(OUT_DIM);
  localparam int FC_W    = $clog2(IN_DIM + 1);
  localparam int K_W     = $clog2(EXP_DEPTH);

  localparam int ACC_W  = 40;
  localparam int E_W    = 33;
  localparam int DIFF_W = 32;
  localparam int F_W    = 12;
  localparam int SUM_W  = E_W + $clog2(OUT_DIM);
  localparam int NUM_W  = E_W + 16;

  typedef enum logic [1:0] {
    FN_WEIGHT = 2'd0,
    FN_BIAS   = 2'd1,
    FN_FEAT   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef logic [E_W-1:0] exp_tab_t [EXP_DEPTH];

  // exp(-k/16) in Q1.32, built by repeated rounded multiply by exp(-1/16)
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] t;
    exp_tab_t    tab;
    t = 64'h1_0000_0000;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      tab[k] = t[E_W-1:0];
      t = (t * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // clamp a 41-bit signed sum to the signed 40-bit range
  function automatic logic [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
    logic [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/dense_layer_softmax_unit.sv -----
// Top level: fully connected layer with fixed-point softmax over its outputs.
`timescale 1ns / 1ps
// Takes one word at a time. A weight or bias write leaves the input ready for the next
// word. A feature within the first IN_DIM of a vector holds the input off while one
// multiplier walks the outputs, reading the weight RAM and the accumulator RAM once per
// output and writing each sum back from the second MAC stage. A feature with tlast then
// adds biases (a read and a write state per output), takes exp of each output against the
// maximum (table lookup plus interpolation multiply), and divides each exp by the sum
// with a bit-serial divider (per result: one read, one start, 49 quotient steps and a
// handoff through the done flag, then the word is shown until the output takes it).
// Accumulators and biases sit in small RAMs with per-entry valid bits, so reset needs no
// clearing pass; the weight RAM is undefined until written.
module dense_layer_softmax_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func[1:0], index[11:2], value[27:12], zero pad
  input  logic        in_tlast,   // last feature of a vector
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // class_index[3:0], probability[19:4], zero pad
  output logic        out_tlast   // last probability of a vector
);
  import dls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_ZRD, S_ZWR, S_ERD, S_ELK, S_EMUL, S_EWR,
    S_PRD, S_PST, S_PDIV, S_POUT
  } state_t;

  state_t state_r;

  // input word fields
  logic [1:0]  in_func;
  logic [9:0]  in_index;
  logic [15:0] in_value;
  logic        in_acc;

  assign in_func  = in_tdata[1:0];
  assign in_index = in_tdata[11:2];
  assign in_value = in_tdata[27:12];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  logic [FC_W-1:0]  fcnt_r;
  logic [WA_W-1:0]  base_r;
  logic [15:0]      val_r;
  logic             last_r;
  logic [OJ_W-1:0]  j_r;
  logic             iss_on_r;
  logic             s1_v_r, s2_v_r;
  logic [OJ_W-1:0]  s1_j_r, s2_j_r;
  logic signed [31:0] prod_r;
  logic [OUT_DIM-1:0] acc_vld_r, bias_vld_r;
  logic             acc_rv_r, bias_rv_r;
  logic [ACC_W-1:0] mx_r;
  logic [SUM_W-1:0] sum_r;
  logic             e_zero_r;
  logic [E_W-1:0]   a_r;
  logic [DIFF_W-1:0] diff_r;
  logic [F_W-1:0]   f_r;
  logic [DIFF_W+F_W-1:0] mul_r;
  logic             out_tvalid_r;
  logic [3:0]       out_class_r;
  logic [15:0]      out_prob_r;
  logic             out_last_r;
  logic             div_start_r;

  // RAM ports
  logic             w_we;
  logic [WA_W-1:0]  w_waddr, w_raddr;
  logic [15:0]      w_rdata;
  logic             b_we;
  logic [OJ_W-1:0]  b_waddr;
  logic [15:0]      b_rdata;
  logic             a_we;
  logic [OJ_W-1:0]  a_waddr, a_raddr;
  logic [ACC_W-1:0] a_wdata, a_rdata;

  logic [ACC_W-1:0] accval;
  logic [15:0]      bval;
  logic [ACC_W-1:0] mac_sum, z_val;
  logic [ACC_W:0]   d_val;
  logic [K_W-1:0]   kidx;
  logic [E_W-1:0]   ta, tb, e_val;
  logic [NUM_W-1:0] div_num, div_quo;
  logic             div_done;

  assign w_we    = in_acc && (in_func == FN_WEIGHT) && (int'(in_index) < W_DEPTH);
  assign w_waddr = WA_W'(in_index);
  assign w_raddr = WA_W'(base_r + WA_W'(j_r));
  assign b_we    = in_acc && (in_func == FN_BIAS) && (int'(in_index) < OUT_DIM);
  assign b_waddr = OJ_W'(in_index);
  assign a_raddr = (state_r == S_MAC) ? s1_j_r : j_r;

  assign accval = acc_rv_r  ? a_rdata : '0;
  assign bval   = bias_rv_r ? b_rdata : '0;

  always_comb begin
    mac_sum = sat40({accval[ACC_W-1], accval} + {{9{prod_r[31]}}, prod_r});
    z_val   = sat40({accval[ACC_W-1], accval} + {{17{bval[15]}}, bval, 8'h00});
    d_val   = {mx_r[ACC_W-1], mx_r} - {accval[ACC_W-1], accval};
    kidx    = d_val[F_W +: K_W];
    ta      = EXP_TAB[kidx];
    tb      = (int'(kidx) == EXP_DEPTH - 1) ? '0 : EXP_TAB[K_W'(kidx + 1'b1)];
    e_val   = e_zero_r ? '0 : E_W'(a_r - E_W'(mul_r >> F_W));
    div_num = {accval[E_W-1:0], 16'h0000} + NUM_W'(sum_r >> 1);
  end

  // accumulator RAM write mux: MAC write-back, z write, exp write
  always_comb begin
    a_we    = 1'b0;
    a_waddr = j_r;
    a_wdata = z_val;
    case (state_r)
      S_MAC: begin
        a_we    = s2_v_r;
        a_waddr = s2_j_r;
        a_wdata = mac_sum;
      end
      S_ZWR: begin
        a_we = 1'b1;
      end
      S_EWR: begin
        a_we    = 1'b1;
        a_wdata = ACC_W'(e_val);
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  dls_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  dls_ram #(.WIDTH(16), .DEPTH(OUT_DIM)) u_bram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_value),
    .raddr(j_r), .rdata(b_rdata)
  );

  dls_ram #(.WIDTH(ACC_W), .DEPTH(OUT_DIM)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  dls_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num(div_num), .den(sum_r),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fcnt_r       <= '0;
      j_r          <= '0;
      iss_on_r     <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      acc_vld_r    <= '0;
      bias_vld_r   <= '0;
      acc_rv_r     <= 1'b0;
      bias_rv_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      div_start_r  <= 1'b0;
    end else begin
      acc_rv_r    <= acc_vld_r[a_raddr];
      bias_rv_r   <= bias_vld_r[j_r];
      div_start_r <= 1'b0;
      // MAC pipeline: stage 1 multiplies, stage 2 writes back
      s1_v_r <= iss_on_r;
      s1_j_r <= j_r;
      s2_v_r <= s1_v_r;
      s2_j_r <= s1_j_r;
      prod_r <= $signed(val_r) * $signed(w_rdata);
      if (a_we) begin
        acc_vld_r[a_waddr] <= 1'b1;
      end
      if (b_we) begin
        bias_vld_r[b_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_func == FN_FEAT) begin
            val_r  <= in_value;
            last_r <= in_tlast;
            j_r    <= '0;
            if (int'(fcnt_r) < IN_DIM) begin
              base_r   <= WA_W'(int'(fcnt_r) * OUT_DIM);
              fcnt_r   <= fcnt_r + 1'b1;
              iss_on_r <= 1'b1;
              state_r  <= S_MAC;
            end else if (in_tlast) begin
              state_r <= S_ZRD;
            end
          end
        end
        S_MAC: begin
          if (iss_on_r) begin
            j_r <= j_r + 1'b1;
            if (int'(j_r) == OUT_DIM - 1) begin
              iss_on_r <= 1'b0;
            end
          end else if (!s1_v_r && !s2_v_r) begin
            j_r     <= '0;
            state_r <= last_r ? S_ZRD : S_IDLE;
          end
        end
        S_ZRD: begin
          state_r <= S_ZWR;
        end
        S_ZWR: begin
          if (j_r == '0 || $signed(z_val) > $signed(mx_r)) begin
            mx_r <= z_val;
          end
          if (int'(j_r) == OUT_DIM - 1) begin
            j_r     <= '0;
            sum_r   <= '0;
            state_r <= S_ERD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ZRD;
          end
        end
        S_ERD: begin
          state_r <= S_ELK;
        end
        S_ELK: begin
          e_zero_r <= (d_val >> F_W) >= (ACC_W + 1)'(EXP_DEPTH);
          a_r      <= ta;
          diff_r   <= DIFF_W'(ta - tb);
          f_r      <= d_val[F_W-1:0];
          state_r  <= S_EMUL;
        end
        S_EMUL: begin
          mul_r   <= diff_r * f_r;
          state_r <= S_EWR;
        end
        S_EWR: begin
          sum_r <= sum_r + SUM_W'(e_val);
          if (int'(j_r) == OUT_DIM - 1) begin
            j_r     <= '0;
            state_r <= S_PRD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ERD;
          end
        end
        S_PRD: begin
          state_r <= S_PST;
        end
        S_PST: begin
          div_start_r <= 1'b1;
          state_r     <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            out_tvalid_r <= 1'b1;
            out_class_r  <= 4'(j_r);
            out_last_r   <= (int'(j_r) == N_RES - 1);
            if (sum_r == '0) begin
              out_prob_r <= '0;
            end else if (div_quo > NUM_W'(16'hFFFF)) begin
              out_prob_r <= 16'hFFFF;
            end else begin
              out_prob_r <= div_quo[15:0];
            end
            state_r <= S_POUT;
          end
        end
        S_POUT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (int'(j_r) == N_RES - 1) begin
              // vector done: drop accumulators and restart the count
              acc_vld_r <= '0;
              fcnt_r    <= '0;
              j_r       <= '0;
              state_r   <= S_IDLE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_PRD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'h0, out_prob_r, out_class_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_out_only_in_pout: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> state_r == S_POUT)
    else $error("result word shown outside the output state");

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fcnt_r) <= IN_DIM)
    else $error("feature count past input dimension");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_PDIV)
    else $error("divider finished while not awaited");

  a_mac_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && !iss_on_r && !s1_v_r && !s2_v_r) |=> state_r != S_MAC)
    else $error("MAC phase did not exit after draining");
`endif

endmodule

// ----- rtl/dls_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module dls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dls_div.sv -----
// Restoring divider, one quotient bit per cycle while busy.
`timescale 1ns / 1ps
module dls_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dls_pkg::NUM_W-1:0] num,
  input  logic [dls_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic [dls_pkg::NUM_W-1:0] quo
);
  import dls_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [SUM_W-1:0] rem_r;
  logic [SUM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? SUM_W'(rem_sh - {1'b0, den_r}) : SUM_W'(rem_sh);
        num_r <= {num_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ----- dv/softmax_scoreboard.sv -----
// Checker for the dense layer softmax block: watches both streams and predicts results.
`timescale 1ns / 1ps
module softmax_scoreboard
  import dls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [3:0]  cls;
    logic [15:0] prob;
    logic        fin;
  } prob_word_t;

  prob_word_t           prob_q[$];
  longint unsigned      exp_lut[EXP_DEPTH];
  logic signed [15:0]   wmem[W_DEPTH];
  logic signed [15:0]   bmem[OUT_DIM];
  longint               acc[OUT_DIM];
  int                   feat_cnt;

  assign pending = prob_q.size();

  function automatic longint clamp40(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic longint unsigned exp_of_gap(longint unsigned d);
    longint unsigned k, f, a, b;
    k = d >> 12;
    f = d & 64'd4095;
    if (k >= EXP_DEPTH) return 0;
    a = exp_lut[k];
    b = (k + 1 < EXP_DEPTH) ? exp_lut[k+1] : 0;
    return a - (((a - b) * f) >> 12);
  endfunction

  // apply one accepted input word to the shadow state
  task automatic absorb_word(logic [1:0] fn, logic [9:0] idx, logic signed [15:0] val,
                             logic lst);
    longint          z[OUT_DIM];
    longint unsigned e[OUT_DIM];
    longint unsigned total, p;
    longint          top;
    prob_word_t      w;
    case (fn)
      FN_WEIGHT: if (idx < W_DEPTH) wmem[idx] = val;
      FN_BIAS:   if (idx < OUT_DIM) bmem[idx] = val;
      FN_FEAT: begin
        if (feat_cnt < IN_DIM) begin
          for (int j = 0; j < OUT_DIM; j++)
            acc[j] = clamp40(acc[j] + longint'(val) * longint'(wmem[feat_cnt*OUT_DIM+j]));
          feat_cnt++;
        end
        if (lst) begin
          for (int j = 0; j < OUT_DIM; j++) z[j] = clamp40(acc[j] + longint'(bmem[j]) * 256);
          top = z[0];
          for (int j = 1; j < OUT_DIM; j++) if (z[j] > top) top = z[j];
          total = 0;
          for (int j = 0; j < OUT_DIM; j++) begin
            e[j] = exp_of_gap(longint'(top - z[j]));
            total += e[j];
          end
          for (int j = 0; j < N_RES; j++) begin
            p = 0;
            if (total != 0) begin
              p = ((e[j] << 16) + (total >> 1)) / total;
              if (p > 65535) p = 65535;
            end
            w.cls  = j[3:0];
            w.prob = p[15:0];
            w.fin  = (j == N_RES - 1);
            prob_q.push_back(w);
          end
          for (int j = 0; j < OUT_DIM; j++) acc[j] = 0;
          feat_cnt = 0;
        end
      end
      default: ;  // unknown func: drop
    endcase
  endtask

  initial begin
    longint unsigned t;
    t = 64'h1_0000_0000;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      exp_lut[k] = t;
      t = (t * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    for (int j = 0; j < OUT_DIM; j++) begin
      bmem[j] = 0;
      acc[j]  = 0;
    end
    feat_cnt   = 0;
    fail_count = 0;
  end

  always @(posedge clk) begin
    prob_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        absorb_word(in_tdata[1:0], in_tdata[11:2], in_tdata[27:12], in_tlast);
      if (out_tvalid && out_tready) begin
        if (prob_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected word cls=%0d prob=%0d last=%0b",
                     out_tdata[3:0], out_tdata[19:4], out_tlast);
        end else begin
          want = prob_q.pop_front();
          if (want.cls !== out_tdata[3:0] || want.prob !== out_tdata[19:4] ||
              want.fin !== out_tlast || out_tdata[23:20] !== 4'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: exp cls=%0d prob=%0d last=%0b, got cls=%0d prob=%0d last=%0b",
                       want.cls, want.prob, want.fin,
                       out_tdata[3:0], out_tdata[19:4], out_tlast);
          end
        end
      end
    end
  end

endmodule

// ----- dv/dense_layer_softmax_unit_tb.sv -----
// Testbench top for the dense layer softmax block: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module dense_layer_softmax_unit_tb;
  import dls_pkg::*;

  // weight rows filled up front; no vector runs longer than this
  localparam int FILL_ROWS = 8;
  localparam int N_ITEMS   = 280;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // func[1:0], index[11:2], value[27:12], zero pad
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // class_index[3:0], probability[19:4], zero pad
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          send_idle;  // percent of cycles the sender holds off
  int          recv_idle;  // percent of cycles the receiver stalls
  int          sent;

  dense_layer_softmax_unit dut (.*);

  softmax_scoreboard chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .fail_count, .pending
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // random receiver stalls, set by the current idle phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // drive one word, with random hold-off before it, and return on the accepting edge
  task automatic push_word(func_t fn, logic [9:0] idx, logic [15:0] val, logic lst);
    if (sent >= (2 * N_ITEMS) / 3) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (sent >= N_ITEMS / 3) begin
      send_idle = 47;
      recv_idle = 22;
    end
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, val, idx, fn};
    in_tlast  <= lst;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sent++;
  endtask

  // a vector of n features with random values; noise words occasionally mixed in
  task automatic push_vector(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0)
        push_word(FN_NONE, 10'($urandom), 16'($urandom), 1'($urandom));
      push_word(FN_FEAT, 10'($urandom), 16'($urandom), i == n - 1);
    end
  endtask

  initial begin
    int choice;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    send_idle  = 22;
    recv_idle  = 47;
    sent       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the weight rows that features can reach so none reads an unwritten entry
    for (int a = 0; a < FILL_ROWS * OUT_DIM; a++) begin
      case (a % 7)
        0:       push_word(FN_WEIGHT, 10'(a), 16'h7FFF, a[0]);
        1:       push_word(FN_WEIGHT, 10'(a), 16'h8000, 1'b0);
        default: push_word(FN_WEIGHT, 10'(a), 16'($urandom), 1'($urandom));
      endcase
    end

    // directed: bias extremes, out-of-range bias, unknown func, value extremes
    push_word(FN_BIAS, 10'd0, 16'h7FFF, 1'b1);
    push_word(FN_BIAS, 10'd15, 16'h8000, 1'b0);
    push_word(FN_BIAS, 10'd16, 16'h1234, 1'b0);
    push_word(FN_BIAS, 10'h3FF, 16'hFFFF, 1'b0);
    push_word(FN_NONE, 10'h3FF, 16'hFFFF, 1'b1);
    push_word(FN_FEAT, 10'd0, 16'h7FFF, 1'b1);
    push_word(FN_FEAT, 10'h3FF, 16'h8000, 1'b0);
    push_word(FN_FEAT, 10'd0, 16'h0000, 1'b1);
    push_word(FN_FEAT, 10'd0, 16'h0001, 1'b0);
    push_word(FN_FEAT, 10'd0, 16'hFFFF, 1'b0);
    push_word(FN_FEAT, 10'd0, 16'h0100, 1'b1);

    // random part; idle phases follow the word count
    while (sent < N_ITEMS) begin
      choice = $urandom_range(99);
      if (choice < 65)      push_vector($urandom_range(1, 6));
      else if (choice < 68) push_vector($urandom_range(FILL_ROWS - 1, FILL_ROWS));
      else if (choice < 83)
        push_word(FN_BIAS,
                  ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15)),
                  16'($urandom), 1'($urandom));
      else if (choice < 95)
        push_word(FN_WEIGHT, 10'($urandom), 16'($urandom), 1'($urandom));
      else
        push_word(FN_NONE, 10'($urandom), 16'($urandom), 1'($urandom));
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // let the checker take the last word, drain every expected word, then a quiet spell
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dls_pkg.sv
rtl/dls_ram.sv
rtl/dls_div.sv
rtl/dense_layer_softmax_unit.sv
dv/softmax_scoreboard.sv
dv/dense_layer_softmax_unit_tb.sv
